### hw/rtl/r4rp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r4rp_pkg: shared types and constants of the RAID-4 request planner
// Array geometry, request and result codes, and the divide-by-data-disks
// reciprocal used by the block mapping.
// ----------------------------------------------------------------------------
package r4rp_pkg;

  // Array geometry. Disk 1 is parity, disks 2..DISK_COUNT hold data.
  localparam int DISK_COUNT      = 4;
  localparam int BLOCKS_PER_DISK = 1024;
  localparam int HEADER_BLOCKS   = 1;
  localparam int PARITY_DISK     = 1;
  localparam int FIRST_DATA_DISK = 2;
  localparam int DATA_DISKS      = DISK_COUNT - 1;

  // Field widths fixed by the request and result formats.
  localparam int KIND_W   = 2;
  localparam int LB_W     = 16;
  localparam int DN_W     = 4;
  localparam int DISK_W   = 3;
  localparam int PBLK_W   = 10;
  localparam int MASK_W   = 8;
  localparam int CODE_W   = 3;

  localparam int unsigned DATA_BLOCK_LIMIT =
    int'(DATA_DISKS) * int'(BLOCKS_PER_DISK - 1);

  localparam logic [MASK_W-1:0] MEMBER_MASK =
    MASK_W'(((1 << (DISK_COUNT + 1)) - 1) & ~1);
  localparam logic [MASK_W-1:0] PARITY_BIT = MASK_W'(1 << PARITY_DISK);

  // Quotient by DATA_DISKS as a multiply by a rounded-up reciprocal. With the
  // shift three bits past the dividend width the result is exact for every
  // 16-bit dividend and any divisor up to eight.
  localparam int DIV_SHIFT = LB_W + 3;
  localparam int PROD_W    = LB_W + DIV_SHIFT;
  localparam logic [PROD_W-1:0] DIV_MULT =
    PROD_W'((1 << DIV_SHIFT) / DATA_DISKS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_FAIL   = 2'd2,
    KIND_REPAIR = 2'd3
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_OUT_OF_RANGE = 3'd1,
    STATUS_TOO_MANY     = 3'd2,
    STATUS_ALREADY      = 3'd3,
    STATUS_BAD_DISK     = 3'd4,
    STATUS_NOT_FAULTY   = 3'd5
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    ACT_NONE        = 3'd0,
    ACT_DIRECT_READ = 3'd1,
    ACT_RECON_READ  = 3'd2,
    ACT_PARITY_RMW  = 3'd3,
    ACT_PARITY_REGEN = 3'd4,
    ACT_REBUILD     = 3'd5,
    ACT_MARK_FAULTY = 3'd6
  } action_t;

  typedef struct packed {
    kind_t             kind;
    logic [LB_W-1:0]   logical_block;
    logic [DN_W-1:0]   disk_number;
  } req_t;

  typedef struct packed {
    status_t             status;
    action_t             action;
    logic [DISK_W-1:0]   data_disk;
    logic [PBLK_W-1:0]   physical_block;
    logic [MASK_W-1:0]   read_mask;
    logic [MASK_W-1:0]   faulty_mask;
  } plan_t;

endpackage
`default_nettype wire

### hw/rtl/r4rp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r4rp_req_if: request channel of the RAID-4 request planner
// Valid/ready handshake carrying one read, write, fail or repair request.
// ----------------------------------------------------------------------------
interface r4rp_req_if;
  logic                       valid;
  logic                       ready;
  logic [r4rp_pkg::KIND_W-1:0] kind;
  logic [r4rp_pkg::LB_W-1:0]   logical_block;
  logic [r4rp_pkg::DN_W-1:0]   disk_number;

  modport source (output valid, kind, logical_block, disk_number, input ready);
  modport sink   (input valid, kind, logical_block, disk_number, output ready);
endinterface
`default_nettype wire

### hw/rtl/r4rp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r4rp_rsp_if: result channel of the RAID-4 request planner
// Valid/ready handshake carrying the plan for one request.
// ----------------------------------------------------------------------------
interface r4rp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [r4rp_pkg::CODE_W-1:0]  status;
  logic [r4rp_pkg::CODE_W-1:0]  action;
  logic [r4rp_pkg::DISK_W-1:0]  data_disk;
  logic [r4rp_pkg::PBLK_W-1:0]  physical_block;
  logic [r4rp_pkg::MASK_W-1:0]  read_mask;
  logic [r4rp_pkg::MASK_W-1:0]  faulty_mask;

  modport source (output valid, status, action, data_disk, physical_block,
                  read_mask, faulty_mask, input ready);
  modport sink   (input valid, status, action, data_disk, physical_block,
                  read_mask, faulty_mask, output ready);
endinterface
`default_nettype wire

### hw/rtl/r4rp_plan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r4rp_plan: combinational planner for one request
// Maps a block to its data disk and physical block, applies the fault checks
// and returns the plan together with the updated fault mask.
// ----------------------------------------------------------------------------
module r4rp_plan (
  input  r4rp_pkg::req_t                  req,
  input  logic [r4rp_pkg::MASK_W-1:0]     fault_bits,
  output r4rp_pkg::plan_t                 plan
);
  import r4rp_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [LB_W-1:0]   quot;
  logic [LB_W-1:0]   rem;
  logic [DISK_W-1:0] target;
  logic [MASK_W-1:0] tbit;
  logic [MASK_W-1:0] dbit;
  logic              in_range;
  logic              multi_fault;
  logic              bad_disk;
  logic [MASK_W-1:0] fault_next;

  assign prod   = PROD_W'(req.logical_block) * DIV_MULT;
  assign quot   = prod[DIV_SHIFT +: LB_W];
  assign rem    = req.logical_block - LB_W'(quot * LB_W'(DATA_DISKS));
  assign target = rem[DISK_W-1:0] + DISK_W'(FIRST_DATA_DISK);
  assign tbit   = MASK_W'(1) << target;

  assign dbit = req.disk_number[DN_W-1] ? '0
              : (MASK_W'(1) << req.disk_number[DISK_W-1:0]);

  assign in_range    = {16'd0, req.logical_block} < DATA_BLOCK_LIMIT;
  // More than one bit set: clearing the lowest one leaves something behind.
  assign multi_fault = |(fault_bits & (fault_bits - MASK_W'(1)));
  assign bad_disk    = (req.disk_number == '0) ||
                       (req.disk_number > DN_W'(DISK_COUNT));

  always_comb begin
    plan                = '0;
    plan.status         = STATUS_OK;
    plan.action         = ACT_NONE;
    fault_next          = fault_bits;
    case (req.kind)
      KIND_READ, KIND_WRITE: begin
        if (!in_range) begin
          plan.status = STATUS_OUT_OF_RANGE;
        end else begin
          plan.data_disk      = target;
          plan.physical_block = PBLK_W'(quot) + PBLK_W'(HEADER_BLOCKS);
          if ((fault_bits & tbit) != '0) begin
            if (multi_fault) begin
              plan.status = STATUS_TOO_MANY;
            end else if (req.kind == KIND_READ) begin
              plan.action    = ACT_RECON_READ;
              plan.read_mask = MEMBER_MASK & ~tbit;
            end else begin
              plan.action    = ACT_PARITY_REGEN;
              plan.read_mask = MEMBER_MASK & ~tbit & ~PARITY_BIT;
            end
          end else if (req.kind == KIND_READ) begin
            plan.action    = ACT_DIRECT_READ;
            plan.read_mask = tbit;
          end else begin
            plan.action    = ACT_PARITY_RMW;
            plan.read_mask = tbit | PARITY_BIT;
          end
        end
      end
      KIND_FAIL: begin
        plan.data_disk = req.disk_number[DISK_W-1:0];
        if ((fault_bits & dbit) != '0) begin
          plan.status = STATUS_ALREADY;
        end else if (bad_disk) begin
          plan.status = STATUS_BAD_DISK;
        end else begin
          fault_next  = fault_bits | dbit;
          plan.action = ACT_MARK_FAULTY;
        end
      end
      KIND_REPAIR: begin
        plan.data_disk = req.disk_number[DISK_W-1:0];
        if (bad_disk) begin
          plan.status = STATUS_BAD_DISK;
        end else if ((fault_bits & dbit) == '0) begin
          plan.status = STATUS_NOT_FAULTY;
        end else if (multi_fault) begin
          plan.status = STATUS_TOO_MANY;
        end else begin
          plan.read_mask = MEMBER_MASK & ~dbit;
          fault_next     = fault_bits & ~dbit;
          plan.action    = ACT_REBUILD;
        end
      end
      default: begin
        plan.status = STATUS_OK;
      end
    endcase
    plan.faulty_mask = fault_next;
  end

endmodule
`default_nettype wire

### hw/rtl/raid4_request_planner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raid4_request_planner: RAID-4 request planner with a dedicated parity disk
// Turns read, write, fail and repair requests into disk access plans and
// keeps the faulty-disk mask of the array.
// ----------------------------------------------------------------------------
// Usage:
// A host pushes requests on the req channel (valid/ready). Read and write
// requests carry a logical block; fail and repair requests carry a disk
// number. Each request yields exactly one result on the rsp channel, in
// order: a status, a plan code, the target disk, the physical block, the
// set of disks to read and XOR, and the faulty-disk mask after the request.
// A request is captured into an input register at the edge where it is
// accepted; its plan is written into the result register once that is free,
// and then shows on rsp. One request is taken every cycle as long as
// results are drained.
// The block-to-disk mapping is a multiply by a reciprocal of the data-disk
// count, and the mask checks are single-level bit tricks, so all the work
// fits between the two registers.
// When the receiver stalls, the result register holds its plan and the
// input register still takes one more request; ready drops only when both
// are full. Reset empties both registers and marks every disk healthy.
// ----------------------------------------------------------------------------
module raid4_request_planner (
  input  logic       clk,
  input  logic       rst,
  r4rp_req_if.sink   req,
  r4rp_rsp_if.source rsp
);
  import r4rp_pkg::*;

  req_t              in_q;
  logic              in_valid;
  plan_t             out_q;
  logic              out_valid;
  logic [MASK_W-1:0] fault_bits;
  plan_t             plan;
  logic              out_free;
  logic              advance;

  // The result register frees up when empty or when its plan is taken; a
  // request waiting in the input register moves into it whenever it is free.
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = in_valid && out_free;
  assign req.ready = !in_valid || out_free;

  r4rp_plan u_plan (
    .req        (in_q),
    .fault_bits (fault_bits),
    .plan       (plan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fault_bits <= '0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      // The mask commits together with the plan, so the next request in the
      // input register always sees the effect of the one before it.
      if (advance) begin
        fault_bits <= plan.faulty_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.kind          <= kind_t'(req.kind);
      in_q.logical_block <= req.logical_block;
      in_q.disk_number   <= req.disk_number;
    end
    if (advance) begin
      out_q <= plan;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_q.status;
  assign rsp.action         = out_q.action;
  assign rsp.data_disk      = out_q.data_disk;
  assign rsp.physical_block = out_q.physical_block;
  assign rsp.read_mask      = out_q.read_mask;
  assign rsp.faulty_mask    = out_q.faulty_mask;

  // Only member disks can ever be marked faulty.
  a_mask_members: assert property (@(posedge clk) disable iff (rst)
    (fault_bits & ~MEMBER_MASK) == '0)
    else $error("fault mask holds a non-member disk");

  // Only a fail or a rebuild plan may change the fault mask.
  a_mask_changes: assert property (@(posedge clk) disable iff (rst)
    (advance && plan.action != ACT_MARK_FAULTY && plan.action != ACT_REBUILD)
      |=> $stable(fault_bits))
    else $error("fault mask changed by a plan that must leave it alone");

  // A pending result always reports the current mask.
  a_mask_reported: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.faulty_mask == fault_bits))
    else $error("reported fault mask differs from the stored mask");

  // Requests are refused only when both registers hold work and rsp stalls.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (in_valid && out_valid && !rsp.ready))
    else $error("request channel stalled without backpressure");

endmodule
`default_nettype wire

### bench/tb_raid4_request_planner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_raid4_request_planner: self-checking bench for the RAID-4 request planner
// Drives read, write, fail and repair requests through the request channel
// and compares every plan on the result channel against a predicted plan.
// The array state is followed in the bench itself. Traffic runs under
// several idle and stall patterns, including one long result stall.
// ----------------------------------------------------------------------------
module tb_raid4_request_planner;
  import r4rp_pkg::*;

  // Highest valid logical block + 1: block 0 of every disk holds the header.
  localparam int unsigned BLOCK_LIMIT = DATA_DISKS * (BLOCKS_PER_DISK - 1);
  // Member disks are 1..DISK_COUNT, so bit 0 of the member set is always clear.
  localparam logic [7:0] MEMBERS = 8'(((1 << (DISK_COUNT + 1)) - 1) & ~1);
  localparam logic [7:0] PARITY_SEL = 8'(1 << PARITY_DISK);
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  r4rp_req_if req_ch ();
  r4rp_rsp_if rsp_ch ();

  raid4_request_planner dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests waiting to be offered, and plans waiting to come back in order.
  req_t  pending_requests[$];
  plan_t plans_due[$];

  // Fault mask as the block should hold it, updated at each accepted request.
  logic [7:0] array_faults = '0;
  // Fault mask as it will be once every queued request has been accepted.
  // The stimulus uses it to build sequences that stay out of dead ends.
  logic [7:0] gen_faults = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int error_count    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the plan for one request and advances the fault mask it is
  // given. Rejected requests leave the mask alone.
  function automatic plan_t plan_request(input req_t r, ref logic [7:0] faults);
    plan_t       p;
    logic [7:0]  sel;
    logic [2:0]  disk;
    int unsigned lb;
    bit          bad;
    p = '0;
    p.status = STATUS_OK;
    p.action = ACT_NONE;
    lb = r.logical_block;
    if (r.kind == KIND_READ || r.kind == KIND_WRITE) begin
      if (lb >= BLOCK_LIMIT) begin
        // Out of range: nothing at all is mapped.
        p.status = STATUS_OUT_OF_RANGE;
      end else begin
        disk = 3'(lb % DATA_DISKS + FIRST_DATA_DISK);
        p.data_disk = disk;
        p.physical_block = 10'(lb / DATA_DISKS + HEADER_BLOCKS);
        sel = 8'(1) << disk;
        if ((faults & sel) != 0) begin
          // The target is lost. With a second fault there is no way back,
          // though the mapping is still reported.
          if ($countones(faults) > 1) begin
            p.status = STATUS_TOO_MANY;
          end else if (r.kind == KIND_READ) begin
            p.action = ACT_RECON_READ;
            p.read_mask = MEMBERS & ~sel;
          end else begin
            p.action = ACT_PARITY_REGEN;
            p.read_mask = MEMBERS & ~sel & ~PARITY_SEL;
          end
        end else if (r.kind == KIND_READ) begin
          p.action = ACT_DIRECT_READ;
          p.read_mask = sel;
        end else begin
          // Read-modify-write names the parity disk even when it is faulty.
          p.action = ACT_PARITY_RMW;
          p.read_mask = sel | PARITY_SEL;
        end
      end
    end else begin
      sel = (r.disk_number < 8) ? 8'(1) << r.disk_number[2:0] : 8'h00;
      bad = (r.disk_number == 0) || (r.disk_number > DISK_COUNT);
      p.data_disk = r.disk_number[2:0];
      if (r.kind == KIND_FAIL) begin
        // The already-faulty check comes ahead of the disk range check.
        if ((faults & sel) != 0) begin
          p.status = STATUS_ALREADY;
        end else if (bad) begin
          p.status = STATUS_BAD_DISK;
        end else begin
          faults = faults | sel;
          p.action = ACT_MARK_FAULTY;
        end
      end else begin
        if (bad) begin
          p.status = STATUS_BAD_DISK;
        end else if ((faults & sel) == 0) begin
          p.status = STATUS_NOT_FAULTY;
        end else if ($countones(faults) > 1) begin
          p.status = STATUS_TOO_MANY;
        end else begin
          p.read_mask = MEMBERS & ~sel;
          faults = faults & ~sel;
          p.action = ACT_REBUILD;
        end
      end
    end
    p.faulty_mask = faults;
    return p;
  endfunction

  task automatic queue_request(input kind_t kind, input int lb, input int dn);
    req_t r;
    r.kind = kind;
    r.logical_block = 16'(lb);
    r.disk_number = 4'(dn);
    void'(plan_request(r, gen_faults));
    pending_requests.push_back(r);
  endtask

  // Random request shaped around the current fault state. Unless a second
  // fault is allowed, a fail request never hits a healthy member while one
  // disk is already down: two faults can never be repaired, so that state
  // is left for the last phase.
  function automatic req_t pick_random_request(input bit allow_multi);
    req_t r;
    int   roll;
    int   down;
    roll = $urandom_range(99);
    down = 0;
    for (int d = 1; d < 8; d++) begin
      if (gen_faults[d]) down = d;
    end
    r.logical_block = ($urandom_range(99) < 85) ? 16'($urandom_range(BLOCK_LIMIT - 1))
                                                 : 16'($urandom);
    r.disk_number = 4'($urandom);
    if (roll < 70) begin
      r.kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
    end else if (roll < 85) begin
      r.kind = KIND_FAIL;
      if (down == 0 && $urandom_range(99) < 60) begin
        r.disk_number = 4'($urandom_range(DISK_COUNT, 1));
      end else if (!allow_multi && down != 0 && r.disk_number >= 1 &&
                   r.disk_number <= DISK_COUNT && !gen_faults[r.disk_number]) begin
        r.disk_number = 4'(down);
      end
    end else begin
      r.kind = KIND_REPAIR;
      if (down != 0 && $urandom_range(99) < 70) r.disk_number = 4'(down);
    end
    return r;
  endfunction

  task automatic queue_random_requests(input int count, input bit allow_multi);
    req_t r;
    for (int i = 0; i < count; i++) begin
      r = pick_random_request(allow_multi);
      queue_request(r.kind, r.logical_block, r.disk_number);
    end
  endtask

  // The sender holds off here until every queued request is taken and every
  // plan has come back.
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || req_ch.valid || plans_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_requests(count, 1'b0);
    wait_for_drain();
  endtask

  // Request driver. At an accepting edge the plan of the request on the bus
  // is predicted; then, if the slot is free, the next request goes out or
  // the channel idles. Valid gets at most one assignment per edge.
  always @(posedge clk) begin : request_driver
    req_t bus_req;
    req_t next_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        bus_req.kind = kind_t'(req_ch.kind);
        bus_req.logical_block = req_ch.logical_block;
        bus_req.disk_number = req_ch.disk_number;
        plans_due.push_back(plan_request(bus_req, array_faults));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.kind <= next_req.kind;
          req_ch.logical_block <= next_req.logical_block;
          req_ch.disk_number <= next_req.disk_number;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready. A long hold-off, when one is armed, is counted down here
  // before random stalling resumes.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // Plan monitor: every accepted result is matched against the oldest plan due.
  always @(posedge clk) begin : plan_monitor
    plan_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (plans_due.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual status %0d",
                 $time, rsp_ch.status);
        error_count++;
      end else begin
        want = plans_due.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("action", want.action, rsp_ch.action);
        check_field("data_disk", want.data_disk, rsp_ch.data_disk);
        check_field("physical_block", want.physical_block, rsp_ch.physical_block);
        check_field("read_mask", want.read_mask, rsp_ch.read_mask);
        check_field("faulty_mask", want.faulty_mask, rsp_ch.faulty_mask);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.logical_block = '0;
    req_ch.disk_number = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening on a healthy array, then a single fault on a data
    // disk and on the parity disk, each repaired afterwards.
    queue_request(KIND_READ, 0, 0);
    queue_request(KIND_WRITE, BLOCK_LIMIT - 1, 0);
    queue_request(KIND_READ, BLOCK_LIMIT, 0);
    queue_request(KIND_WRITE, 65535, 15);
    queue_request(KIND_FAIL, 0, 0);
    queue_request(KIND_FAIL, 65535, 15);
    queue_request(KIND_REPAIR, 0, DISK_COUNT + 1);
    queue_request(KIND_REPAIR, 0, 3);
    queue_request(KIND_FAIL, 0, 3);
    queue_request(KIND_FAIL, 0, 3);
    queue_request(KIND_READ, 1, 0);
    queue_request(KIND_WRITE, 4, 0);
    queue_request(KIND_READ, 2, 0);
    queue_request(KIND_WRITE, 0, 0);
    queue_request(KIND_REPAIR, 0, 3);
    queue_request(KIND_FAIL, 0, PARITY_DISK);
    queue_request(KIND_WRITE, 5, 0);
    queue_request(KIND_READ, 6, 0);
    queue_request(KIND_REPAIR, 0, PARITY_DISK);
    wait_for_drain();

    run_phase(0, 0, 250);
    run_phase(58, 0, 250);
    run_phase(0, 58, 250);
    run_phase(25, 25, 200);

    // The receiver stops for a long stretch while the sender keeps pushing,
    // so the two internal registers fill and the block drops ready.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 200;
    queue_random_requests(60, 1'b0);
    wait_for_drain();

    // Last phase: clear any leftover fault, then go into the multiple-fault
    // state, which cannot be left again, and finish with random traffic.
    send_idle_pct = 25;
    recv_stall_pct = 25;
    for (int d = 1; d <= DISK_COUNT; d++) begin
      if (gen_faults[d]) queue_request(KIND_REPAIR, 0, d);
    end
    queue_request(KIND_FAIL, 0, 2);
    queue_request(KIND_FAIL, 0, 4);
    queue_request(KIND_READ, 0, 0);
    queue_request(KIND_WRITE, 3, 0);
    queue_request(KIND_READ, 1, 0);
    queue_request(KIND_REPAIR, 0, 2);
    queue_request(KIND_FAIL, 0, PARITY_DISK);
    queue_request(KIND_FAIL, 0, 3);
    queue_random_requests(120, 1'b1);
    wait_for_drain();

    // Any stray result shows up and is caught during this wait.
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/r4rp_pkg.sv
hw/rtl/r4rp_req_if.sv
hw/rtl/r4rp_rsp_if.sv
hw/rtl/r4rp_plan.sv
hw/rtl/raid4_request_planner.sv
bench/tb_raid4_request_planner.sv
